>>> src/ttt_pkg.sv
// ttt_pkg: shared constants, types and state codes of the transmitter track table
// no dependencies; imported by ttt_ctrl, transmitter_track_table_top and tb
`timescale 1ns / 1ps
`default_nettype none

package ttt_pkg;

    localparam int ADDR_BYTES     = 6;
    localparam int SRC_ADDR_W     = ADDR_BYTES * 8;
    localparam int TIME_W         = 32;
    localparam int TYPE_W         = 4;
    localparam int NUM_TYPES      = 1 << TYPE_W;
    localparam int CNT_W          = 8;
    localparam int SIG_W          = 8;
    localparam int PKT_W          = 32;
    localparam int ROW_W          = NUM_TYPES * CNT_W;
    localparam int SLOT_OUT_W     = 4;
    localparam int DEF_NUM_SLOTS  = 16;

    // one slot entry as kept in the slot memory
    typedef struct packed {
        logic [SRC_ADDR_W-1:0] address;
        logic [TIME_W-1:0]     last_seen;
        logic [PKT_W-1:0]      packets;
        logic [SIG_W-1:0]      signal;
    } ttt_slot_t;

    localparam int SLOT_WORD_W = $bits(ttt_slot_t);

    // memory strobes, shared by both memories
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ttt_mem_ctl_t;

    // one result beat
    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot_index;
        logic                  slot_replaced;
        logic                  is_duplicate;
        logic [PKT_W-1:0]      slot_packet_count;
        logic [PKT_W-1:0]      total_packet_count;
    } ttt_result_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } ttt_state_t;

endpackage

`default_nettype wire

>>> src/transmitter_track_table_top.sv
// transmitter_track_table_top: slot table of radio transmitters with duplicate filter
// depends on ttt_pkg, ttt_ctrl and ttt_ram
`timescale 1ns / 1ps
`default_nettype none

// usage
// - input channel: in_valid / in_ready with one message per beat (address, time,
//   type, counter, signal strength); output channel: out_valid / out_ready with
//   one result beat per message, in order
// - the slot table lives in two synchronous memories: slot entries (address,
//   last-seen time, packet count, signal) and one row of per-type counters per slot
// - a message is taken only when the block is idle; it then walks the slot
//   memory one slot per cycle until the address matches or the last slot is seen,
//   tracking the least recently seen slot on the way, then reads the chosen slot
//   and its counter row and writes both back in the update state
// - the scan ends at the matched slot, or covers all NUM_SLOTS slots on a miss; a new
//   message is taken only after the previous one has been written back
// - after reset a clearing pass zeroes both memories; in_ready stays low during it
// - a result waits in the output register while out_ready is low; the next
//   message is still taken and scanned, and only its write-back waits
module transmitter_track_table_top
    import ttt_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [SRC_ADDR_W-1:0] src_address,
    input  wire logic [TIME_W-1:0]     now_seconds,
    input  wire logic [TYPE_W-1:0]     msg_type,
    input  wire logic [CNT_W-1:0]      msg_counter,
    input  wire logic signed [SIG_W-1:0] signal_strength,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [SLOT_OUT_W-1:0] slot_index,
    output logic                       slot_replaced,
    output logic                       is_duplicate,
    output logic      [PKT_W-1:0]      slot_packet_count,
    output logic      [PKT_W-1:0]      total_packet_count
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    ttt_mem_ctl_t        mem_ctl;
    logic [SLOT_W-1:0]   mem_rd_addr;
    logic [SLOT_W-1:0]   mem_wr_addr;
    ttt_slot_t           slot_rd_data;
    ttt_slot_t           slot_wr_data;
    logic [ROW_W-1:0]    row_rd_data;
    logic [ROW_W-1:0]    row_wr_data;
    logic                out_free;
    logic                res_valid;
    ttt_result_t         result;

    logic                out_valid_reg, out_valid_next;
    ttt_result_t         out_data_reg;

    // output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    ttt_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .src_address  (src_address),
        .now_seconds  (now_seconds),
        .msg_type     (msg_type),
        .msg_counter  (msg_counter),
        .signal_raw   (signal_strength),
        .mem_ctl      (mem_ctl),
        .mem_rd_addr  (mem_rd_addr),
        .mem_wr_addr  (mem_wr_addr),
        .slot_rd_data (slot_rd_data),
        .slot_wr_data (slot_wr_data),
        .row_rd_data  (row_rd_data),
        .row_wr_data  (row_wr_data),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .result       (result)
    );

    // slot entries: address, last-seen time, packet count, signal
    ttt_ram #(
        .WIDTH (SLOT_WORD_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (mem_ctl.wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (mem_ctl.rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (slot_rd_data)
    );

    // per-type message counters, one row per slot, kept when a slot is taken over
    ttt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SLOTS)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (mem_ctl.wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (row_wr_data),
        .rd_en   (mem_ctl.rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (row_rd_data)
    );

    // output beat register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid          = out_valid_reg;
    assign slot_index         = out_data_reg.slot_index;
    assign slot_replaced      = out_data_reg.slot_replaced;
    assign is_duplicate       = out_data_reg.is_duplicate;
    assign slot_packet_count  = out_data_reg.slot_packet_count;
    assign total_packet_count = out_data_reg.total_packet_count;

endmodule

`default_nettype wire

>>> src/ttt_ram.sv
// ttt_ram: generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ttt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/ttt_ctrl.sv
// ttt_ctrl: clearing pass, slot scan and read-modify-write of one slot
// depends on ttt_pkg; drives the slot memory and the type counter memory
`timescale 1ns / 1ps
`default_nettype none

module ttt_ctrl
    import ttt_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [SRC_ADDR_W-1:0] src_address,
    input  wire logic [TIME_W-1:0]     now_seconds,
    input  wire logic [TYPE_W-1:0]     msg_type,
    input  wire logic [CNT_W-1:0]      msg_counter,
    input  wire logic [SIG_W-1:0]      signal_raw,
    output ttt_mem_ctl_t               mem_ctl,
    output logic      [SLOT_W-1:0]     mem_rd_addr,
    output logic      [SLOT_W-1:0]     mem_wr_addr,
    input  wire ttt_slot_t             slot_rd_data,
    output ttt_slot_t                  slot_wr_data,
    input  wire logic [ROW_W-1:0]      row_rd_data,
    output logic      [ROW_W-1:0]      row_wr_data,
    input  wire logic                  out_free,
    output logic                       res_valid,
    output ttt_result_t                result
);

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    ttt_state_t             state_reg,       state_next;
    logic [SLOT_W-1:0]      idx_reg,         idx_next;
    logic [SLOT_W-1:0]      oldest_reg,      oldest_next;
    logic [TIME_W-1:0]      oldest_time_reg, oldest_time_next;
    logic [SLOT_W-1:0]      slot_reg,        slot_next;
    logic                   hit_reg,         hit_next;
    logic [PKT_W-1:0]       total_reg,       total_next;

    logic [SRC_ADDR_W-1:0]  addr_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [TYPE_W-1:0]      type_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [SIG_W-1:0]       sig_reg;

    logic                   accept;
    logic                   match;
    logic                   older;
    logic                   last;
    logic [SLOT_W-1:0]      miss_slot;
    logic [CNT_W-1:0]       old_cnt;
    logic                   dup;
    ttt_slot_t              upd_slot;
    logic [ROW_W-1:0]       upd_row;
    logic [PKT_W-1:0]       total_upd;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

    assign accept    = in_valid && in_ready;
    assign match     = (slot_rd_data.address == addr_reg);
    assign older     = (slot_rd_data.last_seen < oldest_time_reg);
    assign last      = (idx_reg == LAST_IDX);
    assign miss_slot = older ? idx_reg : oldest_reg;
    assign old_cnt   = row_rd_data[type_reg*CNT_W +: CNT_W];
    assign dup       = (old_cnt == cnt_reg);
    assign total_upd = dup ? total_reg : total_reg + PKT_W'(1);
    assign slot_ext  = {{SLOT_OUT_W{1'b0}}, slot_reg};

    // new slot entry and counter row
    always_comb
    begin
        upd_slot           = slot_rd_data;
        upd_row            = row_rd_data;
        upd_slot.last_seen = now_reg;
        if (!hit_reg)
        begin
            upd_slot.address = addr_reg;
            upd_slot.packets = '0;
        end
        if (!dup)
        begin
            upd_slot.packets = upd_slot.packets + PKT_W'(1);
            upd_slot.signal  = sig_reg;
            upd_row[type_reg*CNT_W +: CNT_W] = cnt_reg;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        oldest_next      = oldest_reg;
        oldest_time_next = oldest_time_reg;
        slot_next        = slot_reg;
        hit_next         = hit_reg;
        total_next       = total_reg;
        in_ready         = 1'b0;
        mem_ctl          = '0;
        mem_rd_addr      = idx_reg;
        mem_wr_addr      = idx_reg;
        slot_wr_data     = '0;
        row_wr_data      = '0;
        res_valid        = 1'b0;
        result           = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
                if (last)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    idx_next         = '0;
                    oldest_next      = '0;
                    oldest_time_next = now_seconds;
                    mem_ctl.rd_en    = 1'b1;
                    mem_rd_addr      = '0;
                    state_next       = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                mem_ctl.rd_en = 1'b1;
                if (match)
                begin
                    slot_next   = idx_reg;
                    hit_next    = 1'b1;
                    mem_rd_addr = idx_reg;
                    state_next  = ST_UPDATE;
                end
                else if (last)
                begin
                    slot_next   = miss_slot;
                    hit_next    = 1'b0;
                    mem_rd_addr = miss_slot;
                    state_next  = ST_UPDATE;
                end
                else
                begin
                    if (older)
                    begin
                        oldest_next      = idx_reg;
                        oldest_time_next = slot_rd_data.last_seen;
                    end
                    idx_next    = idx_reg + SLOT_W'(1);
                    mem_rd_addr = idx_reg + SLOT_W'(1);
                end
            end
            ST_UPDATE:
            begin
                // read data holds while the output register is full
                if (out_free)
                begin
                    mem_ctl.wr_en             = 1'b1;
                    mem_wr_addr               = slot_reg;
                    slot_wr_data              = upd_slot;
                    row_wr_data               = upd_row;
                    total_next                = total_upd;
                    res_valid                 = 1'b1;
                    result.slot_index         = slot_ext[SLOT_OUT_W-1:0];
                    result.slot_replaced      = !hit_reg;
                    result.is_duplicate       = dup;
                    result.slot_packet_count  = upd_slot.packets;
                    result.total_packet_count = total_upd;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            idx_reg         <= '0;
            oldest_reg      <= '0;
            oldest_time_reg <= '0;
            slot_reg        <= '0;
            hit_reg         <= 1'b0;
            total_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            oldest_reg      <= oldest_next;
            oldest_time_reg <= oldest_time_next;
            slot_reg        <= slot_next;
            hit_reg         <= hit_next;
            total_reg       <= total_next;
        end
    end

    // captured message fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= src_address;
            now_reg  <= now_seconds;
            type_reg <= msg_type;
            cnt_reg  <= msg_counter;
            sig_reg  <= signal_raw;
        end
    end

endmodule

`default_nettype wire

>>> test/tb.sv
// tb: self-checking bench for the transmitter track table (slot lookup, replacement, duplicates)
// depends on ttt_pkg and transmitter_track_table_top; predicts each result beat from its own slot table
`timescale 1ns / 1ps

module tb;
    import ttt_pkg::*;

    localparam int ADDR_POOL = 24;      // more addresses than slots, so takeovers keep happening
    localparam int DRAIN_CYCLES = DEF_NUM_SLOTS + 8;

    logic                         clk;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [SRC_ADDR_W-1:0]        src_address = '0;
    logic [TIME_W-1:0]            now_seconds = '0;
    logic [TYPE_W-1:0]            msg_type = '0;
    logic [CNT_W-1:0]             msg_counter = '0;
    logic signed [SIG_W-1:0]      signal_strength = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [SLOT_OUT_W-1:0]        slot_index;
    logic                         slot_replaced;
    logic                         is_duplicate;
    logic [PKT_W-1:0]             slot_packet_count;
    logic [PKT_W-1:0]             total_packet_count;

    // own copy of the slot table, advanced once per accepted message beat
    logic [SRC_ADDR_W-1:0]        trk_addr [DEF_NUM_SLOTS];
    logic [TIME_W-1:0]            trk_seen [DEF_NUM_SLOTS];
    logic [PKT_W-1:0]             trk_pkts [DEF_NUM_SLOTS];
    logic [CNT_W-1:0]             trk_ctr  [DEF_NUM_SLOTS][NUM_TYPES];
    logic [SIG_W-1:0]             trk_sig  [DEF_NUM_SLOTS];
    logic [PKT_W-1:0]             trk_total;

    ttt_result_t                  pending_results [$];
    int                           mismatch_count = 0;
    int                           send_idle_pct = 0;
    int                           ready_idle_pct = 0;

    // stimulus bookkeeping: address pool, running wall clock, last counter sent per address/type
    logic [SRC_ADDR_W-1:0]        addr_pool [ADDR_POOL];
    logic [TIME_W-1:0]            wall_clock = '0;
    bit [CNT_W-1:0]               sent_cnt [bit [SRC_ADDR_W+TYPE_W-1:0]];

    transmitter_track_table_top dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .src_address        (src_address),
        .now_seconds        (now_seconds),
        .msg_type           (msg_type),
        .msg_counter        (msg_counter),
        .signal_strength    (signal_strength),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .slot_index         (slot_index),
        .slot_replaced      (slot_replaced),
        .is_duplicate       (is_duplicate),
        .slot_packet_count  (slot_packet_count),
        .total_packet_count (total_packet_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous ceiling on simulated time, well over ten times the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // table after reset: every slot holds address zero, seen at time zero, counters zero
    task automatic clear_table();
        int i;
        int j;
        for (i = 0; i < DEF_NUM_SLOTS; i++)
        begin
            trk_addr[i] = '0;
            trk_seen[i] = '0;
            trk_pkts[i] = '0;
            trk_sig[i]  = '0;
            for (j = 0; j < NUM_TYPES; j++)
                trk_ctr[i][j] = '0;
        end
        trk_total = '0;
    endtask

    // lookup and update for one message; the result beat it should produce joins the queue
    task automatic predict_track(input logic [SRC_ADDR_W-1:0] addr, input logic [TIME_W-1:0] now,
                                 input logic [TYPE_W-1:0] mtype, input logic [CNT_W-1:0] cnt,
                                 input logic [SIG_W-1:0] sig);
        ttt_result_t    res;
        int             i;
        int             slot;
        int             oldest;
        logic [TIME_W-1:0] oldest_time;
        bit             hit;
        bit             dup;
        slot = 0;
        oldest = 0;
        oldest_time = now;
        hit = 1'b0;
        // first matching address wins; otherwise the first strictly least last-seen below now
        for (i = 0; i < DEF_NUM_SLOTS; i++)
        begin
            if (!hit)
            begin
                if (trk_addr[i] == addr)
                begin
                    slot = i;
                    hit = 1'b1;
                end
                else if (trk_seen[i] < oldest_time)
                begin
                    oldest = i;
                    oldest_time = trk_seen[i];
                end
            end
        end
        if (!hit)
        begin
            // takeover keeps the per-type counters of the previous occupant
            slot = oldest;
            trk_addr[slot] = addr;
            trk_pkts[slot] = '0;
        end
        trk_seen[slot] = now;
        dup = (trk_ctr[slot][mtype] == cnt);
        if (!dup)
        begin
            trk_ctr[slot][mtype] = cnt;
            trk_total = trk_total + 1;
            trk_pkts[slot] = trk_pkts[slot] + 1;
            trk_sig[slot] = sig;
        end
        res.slot_index         = slot[SLOT_OUT_W-1:0];
        res.slot_replaced      = !hit;
        res.is_duplicate       = dup;
        res.slot_packet_count  = trk_pkts[slot];
        res.total_packet_count = trk_total;
        pending_results.push_back(res);
    endtask

    // one message beat; valid stays high on return so back-to-back beats need no extra edge
    task automatic send_message(input logic [SRC_ADDR_W-1:0] addr, input logic [TIME_W-1:0] now,
                                input logic [TYPE_W-1:0] mtype, input logic [CNT_W-1:0] cnt,
                                input logic signed [SIG_W-1:0] sig);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        src_address     <= addr;
        now_seconds     <= now;
        msg_type        <= mtype;
        msg_counter     <= cnt;
        signal_strength <= sig;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_track(addr, now, mtype, cnt, sig);
    endtask

    // result side: random back-pressure, each beat checked against the oldest expectation
    always @(posedge clk)
    begin : result_check
        ttt_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: slot %0d replaced %0b dup %0b slot count %0d total %0d",
                             slot_index, slot_replaced, is_duplicate,
                             slot_packet_count, total_packet_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (slot_index !== want.slot_index || slot_replaced !== want.slot_replaced ||
                    is_duplicate !== want.is_duplicate ||
                    slot_packet_count !== want.slot_packet_count ||
                    total_packet_count !== want.total_packet_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch (expected/actual): slot %0d/%0d replaced %0b/%0b dup %0b/%0b slot count %0d/%0d total %0d/%0d",
                                 want.slot_index, slot_index, want.slot_replaced, slot_replaced,
                                 want.is_duplicate, is_duplicate,
                                 want.slot_packet_count, slot_packet_count,
                                 want.total_packet_count, total_packet_count);
                end
            end
        end
        out_ready <= ($urandom_range(99) >= ready_idle_pct);
    end

    // every slot holds address zero after reset, so address zero lands on slot 0
    task automatic test_address_zero();
        send_message(48'h0, 32'h0, 4'h0, 8'h00, 8'sh00);            // stored counter zero: dropped
        send_message(48'h0, 32'h10, 4'hF, 8'hFF, -8'sd128);
        send_message(48'h0, 32'h10, 4'hF, 8'hFF, 8'sd127);          // same counter again
    endtask

    // misses: nothing below now takes slot 0, ties take the first slot, hits refresh
    task automatic test_replacement();
        send_message(48'hFFFF_FFFF_FFFF, 32'h0, 4'h3, 8'h01, 8'sd127);
        send_message(48'h0000_0000_0001, 32'h20, 4'h1, 8'h02, 8'sd3);
        send_message(48'h8000_0000_0000, 32'h21, 4'h2, 8'h05, -8'sd1);
        send_message(48'h0000_0000_0001, 32'h22, 4'h1, 8'h03, 8'sd4);
        send_message(48'hA5A5_5A5A_0F0F, 32'h05, 4'h8, 8'h80, 8'sd64);
        send_message(48'h0, 32'h30, 4'h0, 8'h7F, -8'sd64);
    endtask

    // duplicate filter works per slot and per message type
    task automatic test_duplicates();
        send_message(48'h0000_0000_0001, 32'h31, 4'h1, 8'h03, 8'sd10);
        send_message(48'h0000_0000_0001, 32'h32, 4'h2, 8'h03, 8'sd11);
        send_message(48'h0000_0000_0001, 32'h33, 4'h2, 8'h03, 8'sd12);
        send_message(48'h0000_0000_0001, 32'h34, 4'h7, 8'h00, 8'sd13);
    endtask

    // takeover at time zero lands on slot 0, whose old type counters still stand
    task automatic test_counter_kept_on_takeover();
        send_message(48'h5A5A_A5A5_F0F0, 32'h0, 4'h1, 8'h03, -8'sd20);
        send_message(48'h5A5A_A5A5_F0F0, 32'h0, 4'h1, 8'h04, -8'sd21);
    endtask

    task automatic test_extremes();
        send_message(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 8'hFF, -8'sd128);
        send_message(48'h7FFF_FFFF_FFFE, 32'hFFFF_FFFF, 4'h0, 8'h00, 8'sd127);
        send_message(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFE, 4'hF, 8'hFE, 8'sd0);
    endtask

    // mostly a known pool of transmitters on a running clock, counters repeating or stepping
    task automatic test_random_traffic(input int n_items, input int tx_idle, input int rx_idle);
        logic [SRC_ADDR_W-1:0]          addr;
        logic [TYPE_W-1:0]              mtype;
        logic [CNT_W-1:0]               cnt;
        logic [SRC_ADDR_W+TYPE_W-1:0]   key;
        int                             pick;
        int                             i;
        send_idle_pct = tx_idle;
        ready_idle_pct = rx_idle;
        for (i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                addr = addr_pool[$urandom_range(ADDR_POOL / 2 - 1)];
            else if (pick < 90)
                addr = addr_pool[$urandom_range(ADDR_POOL - 1)];
            else
            begin
                addr[47:32] = 16'($urandom);
                addr[31:0]  = $urandom;
            end
            // wall clock mostly creeps forward; now and then it stalls, jumps or steps back
            pick = $urandom_range(99);
            if (pick < 80)
                wall_clock = wall_clock + $urandom_range(3);
            else if (pick < 90)
                wall_clock = wall_clock - $urandom_range(20);
            else
                wall_clock = $urandom;
            mtype = TYPE_W'($urandom_range(NUM_TYPES - 1));
            key = {addr, mtype};
            pick = $urandom_range(99);
            if (sent_cnt.exists(key) && pick < 35)
                cnt = sent_cnt[key];
            else if (sent_cnt.exists(key) && pick < 85)
                cnt = sent_cnt[key] + 8'd1;
            else
                cnt = CNT_W'($urandom);
            sent_cnt[key] = cnt;
            send_message(addr, wall_clock, mtype, cnt, SIG_W'($urandom));
        end
    endtask

    initial
    begin : main
        int i;
        clear_table();
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (i = 2; i < ADDR_POOL; i++)
        begin
            addr_pool[i][47:32] = 16'($urandom);
            addr_pool[i][31:0]  = $urandom;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // in_ready stays low through the clearing pass, so the first beat simply waits

        send_idle_pct = 19;
        ready_idle_pct = 63;
        test_address_zero();
        test_replacement();
        test_duplicates();
        test_counter_kept_on_takeover();
        test_extremes();

        test_random_traffic(600, 19, 63);
        test_random_traffic(600, 63, 19);
        test_random_traffic(550, 0, 0);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // let a stray extra beat show up before judging
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
